### hw/rtl/ole_pkg.sv
// Shared constants, codes and types of the ordered list engine.
package ole_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int REQ_W      = 3;
    localparam int POS_W      = 8;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SORT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_ELEM  = 2'd3;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic [STAT_W-1:0]       status;
        logic                    last;
    } result_t;

endpackage

### hw/rtl/ole_req_if.sv
// Request channel of the ordered list engine.
interface ole_req_if;
    logic                             valid;
    logic                             ready;
    logic [ole_pkg::REQ_W-1:0]        req_type;
    logic [ole_pkg::POS_W-1:0]        position;
    logic signed [ole_pkg::VAL_W-1:0] value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

### hw/rtl/ole_rsp_if.sv
// Result channel of the ordered list engine.
interface ole_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [ole_pkg::VAL_W-1:0] out_value;
    logic [ole_pkg::STAT_W-1:0]       status;
    logic                             last;

    modport source (output valid, output out_value, output status, output last,
                    input ready);
    modport sink   (input valid, input out_value, input status, input last,
                    output ready);
endinterface

### hw/rtl/ole_outreg.sv
// One-entry output register that holds a result item until the receiver takes it.
module ole_outreg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ole_pkg::result_t load_data,
    output logic             free,
    ole_rsp_if.source        rsp
);
    import ole_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.out_value = data_reg.out_value;
    assign rsp.status    = data_reg.status;
    assign rsp.last      = data_reg.last;

endmodule

### hw/rtl/ordered_list_engine_unit.sv
// Ordered list engine: bounded list of signed values kept in a synchronous memory.
//
// Channels: req takes one request item (req_type, position, value); rsp gives
// result items (out_value, status, last). ready on req is high only while the
// engine is idle, so one request is worked on at a time.
// Every request but dump and unused codes gives one status item with last set; dump gives one
// item per element, last on the final one, or one empty status item.
// Insert and delete move the elements from the clamped position p to the end
// one place at a time through the single read and single write port of the
// list memory, whose reads are registered; sort moves elements over the same
// ports one per step, and dump reads one element at a time.
// Unused request codes are dropped with no result.
// Reset empties the list at once (element count to zero); the memory needs no
// clearing pass because only entries below the count are ever read.
// A stalled receiver holds the output register; the engine then waits with the
// next result and takes no new request until its last result is registered.
module ordered_list_engine_unit (
    input  logic      clk,
    input  logic      rst_n,
    ole_req_if.sink   req,
    ole_rsp_if.source rsp
);
    import ole_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_SORT_KEY,
        S_SORT_LOAD,
        S_SORT_CMP,
        S_SORT_PUT,
        S_DUMP_RD,
        S_DUMP_WR,
        S_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        j_reg, j_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic [STAT_W-1:0]       stat_reg, stat_next;

    logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
    logic signed [VAL_W-1:0] rdata_reg;
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic signed [VAL_W-1:0] mem_wdata;

    logic             out_load;
    result_t          out_data;
    logic             out_free;
    logic             accept;
    logic [CNT_W-1:0] pos_clamp;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign pos_clamp = (req.position > POS_W'(count_reg)) ? count_reg
                                                           : CNT_W'(req.position);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        key_next   = key_reg;
        stat_next  = stat_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = '0;
        mem_raddr  = '0;
        mem_wdata  = rdata_reg;
        out_load   = 1'b0;
        out_data   = '{out_value: '0, status: stat_reg, last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next = pos_clamp;
                    val_next = req.value;
                    unique case (req.req_type)
                        REQ_INSERT:
                        begin
                            if (count_reg == CNT_W'(LIST_DEPTH))
                            begin
                                stat_next  = ST_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (POS_W'(count_reg) <= req.position)
                            begin
                                stat_next  = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = pos_clamp;
                                state_next = S_DEL_RD;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            stat_next  = (count_reg == '0) ? ST_EMPTY : ST_DONE;
                            count_next = '0;
                            state_next = S_RESP;
                        end
                        REQ_SORT:
                        begin
                            stat_next = ST_DONE;
                            i_next    = CNT_W'(1);
                            if (count_reg > CNT_W'(1))
                            begin
                                state_next = S_SORT_KEY;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        REQ_DUMP:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                stat_next  = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // shift elements up one place from the end down to the insert point
            S_INS_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(idx_reg - CNT_W'(1));
                    state_next = S_INS_WR;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ADDR_W'(pos_reg);
                    mem_wdata  = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    stat_next  = ST_DONE;
                    state_next = S_RESP;
                end
            end

            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(idx_reg);
                idx_next   = idx_reg - CNT_W'(1);
                state_next = S_INS_RD;
            end

            // shift elements down one place from the delete point to the end
            S_DEL_RD:
            begin
                if (idx_reg + CNT_W'(1) < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(idx_reg + CNT_W'(1));
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    stat_next  = ST_DONE;
                    state_next = S_RESP;
                end
            end

            S_DEL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(idx_reg);
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_DEL_RD;
            end

            S_SORT_KEY:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(i_reg);
                j_next     = i_reg;
                state_next = S_SORT_LOAD;
            end

            S_SORT_LOAD:
            begin
                key_next   = rdata_reg;
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(j_reg - CNT_W'(1));
                state_next = S_SORT_CMP;
            end

            // rdata holds element j-1; move it up while it is not below the key
            S_SORT_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(j_reg);
                if (rdata_reg >= key_reg)
                begin
                    j_next = j_reg - CNT_W'(1);
                    if (j_reg > CNT_W'(1))
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ADDR_W'(j_reg - CNT_W'(2));
                    end
                    else
                    begin
                        state_next = S_SORT_PUT;
                    end
                end
                else
                begin
                    mem_wdata = key_reg;
                    i_next    = i_reg + CNT_W'(1);
                    if (i_reg + CNT_W'(1) < count_reg)
                    begin
                        state_next = S_SORT_KEY;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_SORT_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(j_reg);
                mem_wdata = key_reg;
                i_next    = i_reg + CNT_W'(1);
                if (i_reg + CNT_W'(1) < count_reg)
                begin
                    state_next = S_SORT_KEY;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_DUMP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(idx_reg);
                state_next = S_DUMP_WR;
            end

            // rdata stays put until the output register has room
            S_DUMP_WR:
            begin
                out_data = '{out_value: rdata_reg, status: ST_ELEM,
                             last: (idx_reg + CNT_W'(1) == count_reg)};
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (idx_reg + CNT_W'(1) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            pos_reg   <= '0;
            stat_reg  <= ST_DONE;
            val_reg   <= '0;
            key_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pos_reg   <= pos_next;
            stat_reg  <= stat_next;
            val_reg   <= val_next;
            key_reg   <= key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            list_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= list_mem[mem_raddr];
        end
    end

    ole_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (out_data),
        .free      (out_free),
        .rsp       (rsp)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("element count above list depth");

    a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re && (mem_waddr == mem_raddr)))
        else $error("read and write of the same entry in one cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !rsp.valid || rsp.ready)
        else $error("result loaded over an untaken item");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg == $past(count_reg) - CNT_W'(1)) ||
            (count_reg == '0))
        else $error("element count changed by more than one");

endmodule
